/* hw/rtl/eul2rot_pkg.sv */
// ----------------------------------------------------------------------------
// eul2rot_pkg
// Shared constants for the Euler angle to rotation matrix core: CORDIC
// step count, internal widths and the arctangent table.
// ----------------------------------------------------------------------------
`default_nettype none

package eul2rot_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int CORDIC_FRAC  = 30;
  localparam int CW           = 33;  // CORDIC x, y and z width
  localparam int FIELD_W      = 16;  // width of every angle and matrix field
  localparam int NUM_ANGLES   = 3;
  localparam int NUM_ENTRIES  = 9;

  localparam logic signed [CW-1:0] CORDIC_GAIN_INIT = 33'sd652032874;

  typedef logic signed [CW-1:0] cordic_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic cordic_t atan_turn(input int idx);
    cordic_t a;
    a = '0;
    case (idx)
      0:  a = 33'sh020000000;
      1:  a = 33'sh012E4051E;
      2:  a = 33'sh009FB385B;
      3:  a = 33'sh0051111D4;
      4:  a = 33'sh0028B0D43;
      5:  a = 33'sh00145D7E1;
      6:  a = 33'sh000A2F61E;
      7:  a = 33'sh000517C55;
      8:  a = 33'sh00028BE53;
      9:  a = 33'sh000145F2F;
      10: a = 33'sh0000A2F98;
      11: a = 33'sh0000517CC;
      12: a = 33'sh000028BE6;
      13: a = 33'sh0000145F3;
      14: a = 33'sh00000A2FA;
      15: a = 33'sh00000517D;
      16: a = 33'sh0000028BE;
      17: a = 33'sh00000145F;
      18: a = 33'sh000000A30;
      19: a = 33'sh000000518;
      20: a = 33'sh00000028C;
      21: a = 33'sh000000146;
      22: a = 33'sh0000000A3;
      23: a = 33'sh000000051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/euler_angles_to_rotation_core.sv */
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_core
// Converts three binary angles to the entries of R = Rz*Ry*Rx in signed
// fixed point, using three pipelined CORDIC lanes and a product pipeline.
// ----------------------------------------------------------------------------
// Throughput: one word per cycle when not stalled; every stage is a register of the
//   24-step unrolled CORDIC or the product tree, all moving on one enable.
// A stalled output holds the whole pipeline; nothing is dropped.
// Reset (rst_n low, synchronous) clears all valid bits; data is not reset.
`default_nettype none

module euler_angles_to_rotation_core #(
  parameter int ANGLE_BITS = 16,
  parameter int FRAC_BITS  = 14
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  // [15:0] angle_x, [31:16] angle_y, [47:32] angle_z
  input  wire logic [47:0]  in_tdata,
  output logic              out_tvalid,
  input  wire logic         out_tready,
  // [15:0] m00, [31:16] m01, [47:32] m02, [63:48] m10, [79:64] m11,
  // [95:80] m12, [111:96] m20, [127:112] m21, [143:128] m22
  output logic [143:0]      out_tdata
);
  import eul2rot_pkg::*;

  localparam int W    = FRAC_BITS + 4;       // trig fraction bits
  localparam int TW   = W + 2;               // trig word width
  localparam int PW   = 2 * TW;              // product width
  localparam int SW   = PW + 1;              // sum width
  localparam int RS1  = CORDIC_FRAC - W;     // CORDIC to trig shift
  localparam int RS2  = 2 * W - FRAC_BITS;   // product to output shift
  localparam int NST  = CORDIC_STEPS;

  localparam logic signed [CW-1:0] HALF1 = CW'(64'sd1 <<< (RS1 - 1));
  localparam logic signed [PW-1:0] HALFW = PW'(64'sd1 <<< (W - 1));
  localparam logic signed [SW-1:0] HALF2 = SW'(64'sd1 <<< (RS2 - 1));
  localparam logic signed [SW-1:0] LIM   = SW'(64'sd1 <<< FRAC_BITS);
  localparam logic signed [SW-1:0] FMAX  = SW'(64'sd32767);
  localparam logic signed [SW-1:0] FMIN  = -SW'(64'sd32768);

  logic advance;
  assign advance   = !out_tvalid || out_tready;
  assign in_tready = advance;

  // ---------------- fold to [-1/8, +1/8) turn ----------------
  logic                vld_r [0:NST];
  cordic_t             x_r   [0:NST][0:NUM_ANGLES-1];
  cordic_t             y_r   [0:NST][0:NUM_ANGLES-1];
  cordic_t             z_r   [0:NST][0:NUM_ANGLES-1];
  logic [1:0]          q_r   [0:NST][0:NUM_ANGLES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (advance) begin
      vld_r[0] <= in_tvalid;
    end
  end

  for (genvar a = 0; a < NUM_ANGLES; a++) begin : g_fold
    logic [31:0] ext;
    logic [31:0] phase;
    logic [31:0] bias;
    logic [31:0] d;
    assign ext   = {{16{in_tdata[a*FIELD_W+FIELD_W-1]}}, in_tdata[a*FIELD_W +: FIELD_W]};
    assign phase = ext << (32 - ANGLE_BITS);
    assign bias  = phase + 32'h2000_0000;
    assign d     = phase - {bias[31:30], 30'd0};
    always_ff @(posedge clk) begin
      if (advance) begin
        q_r[0][a] <= bias[31:30];
        z_r[0][a] <= cordic_t'($signed(d));
        x_r[0][a] <= CORDIC_GAIN_INIT;
        y_r[0][a] <= '0;
      end
    end
  end

  // ---------------- CORDIC rotation stages ----------------
  for (genvar i = 0; i < NST; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i+1] <= 1'b0;
      end else if (advance) begin
        vld_r[i+1] <= vld_r[i];
      end
    end
    for (genvar a = 0; a < NUM_ANGLES; a++) begin : g_lane
      always_ff @(posedge clk) begin
        if (advance) begin
          q_r[i+1][a] <= q_r[i][a];
          if (!z_r[i][a][CW-1]) begin
            x_r[i+1][a] <= x_r[i][a] - (y_r[i][a] >>> i);
            y_r[i+1][a] <= y_r[i][a] + (x_r[i][a] >>> i);
            z_r[i+1][a] <= z_r[i][a] - atan_turn(i);
          end else begin
            x_r[i+1][a] <= x_r[i][a] + (y_r[i][a] >>> i);
            y_r[i+1][a] <= y_r[i][a] - (x_r[i][a] >>> i);
            z_r[i+1][a] <= z_r[i][a] + atan_turn(i);
          end
        end
      end
    end
  end

  // ---------------- quadrant restore and rounding ----------------
  logic                 tv_r;
  logic signed [TW-1:0] s_r [0:NUM_ANGLES-1];
  logic signed [TW-1:0] c_r [0:NUM_ANGLES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r <= 1'b0;
    end else if (advance) begin
      tv_r <= vld_r[NST];
    end
  end

  for (genvar a = 0; a < NUM_ANGLES; a++) begin : g_quad
    cordic_t cs;
    cordic_t sn;
    cordic_t cs_rnd;
    cordic_t sn_rnd;
    always_comb begin
      case (q_r[NST][a])
        2'd0:    begin cs = x_r[NST][a];  sn = y_r[NST][a];  end
        2'd1:    begin cs = -y_r[NST][a]; sn = x_r[NST][a];  end
        2'd2:    begin cs = -x_r[NST][a]; sn = -y_r[NST][a]; end
        default: begin cs = y_r[NST][a];  sn = -x_r[NST][a]; end
      endcase
    end
    assign cs_rnd = (cs + HALF1) >>> RS1;
    assign sn_rnd = (sn + HALF1) >>> RS1;
    always_ff @(posedge clk) begin
      if (advance) begin
        c_r[a] <= cs_rnd[TW-1:0];
        s_r[a] <= sn_rnd[TW-1:0];
      end
    end
  end

  // ---------------- sy*sx and sy*cx pairs ----------------
  logic                 pv_r;
  logic signed [TW-1:0] pss_r, psc_r;
  logic signed [TW-1:0] s1_r [0:NUM_ANGLES-1];
  logic signed [TW-1:0] c1_r [0:NUM_ANGLES-1];
  logic signed [PW-1:0] pss_w, psc_w;

  assign pss_w = (PW'(s_r[1]) * PW'(s_r[0]) + HALFW) >>> W;
  assign psc_w = (PW'(s_r[1]) * PW'(c_r[0]) + HALFW) >>> W;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else if (advance) begin
      pv_r <= tv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pss_r <= pss_w[TW-1:0];
      psc_r <= psc_w[TW-1:0];
      s1_r  <= s_r;
      c1_r  <= c_r;
    end
  end

  // ---------------- products ----------------
  logic                 mv_r;
  logic signed [PW-1:0] pr_r [0:12];
  logic signed [PW-1:0] nsy;

  assign nsy = -(PW'(s1_r[1]) <<< W);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= 1'b0;
    end else if (advance) begin
      mv_r <= pv_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      pr_r[0]  <= PW'(c1_r[2]) * PW'(c1_r[1]);   // cz*cy
      pr_r[1]  <= PW'(c1_r[2]) * PW'(pss_r);     // cz*pss
      pr_r[2]  <= PW'(s1_r[2]) * PW'(c1_r[0]);   // sz*cx
      pr_r[3]  <= PW'(c1_r[2]) * PW'(psc_r);     // cz*psc
      pr_r[4]  <= PW'(s1_r[2]) * PW'(s1_r[0]);   // sz*sx
      pr_r[5]  <= PW'(s1_r[2]) * PW'(c1_r[1]);   // sz*cy
      pr_r[6]  <= PW'(s1_r[2]) * PW'(pss_r);     // sz*pss
      pr_r[7]  <= PW'(c1_r[2]) * PW'(c1_r[0]);   // cz*cx
      pr_r[8]  <= PW'(s1_r[2]) * PW'(psc_r);     // sz*psc
      pr_r[9]  <= PW'(c1_r[2]) * PW'(s1_r[0]);   // cz*sx
      pr_r[10] <= nsy;                           // -sy
      pr_r[11] <= PW'(c1_r[1]) * PW'(s1_r[0]);   // cy*sx
      pr_r[12] <= PW'(c1_r[1]) * PW'(c1_r[0]);   // cy*cx
    end
  end

  // ---------------- sums, rounding, clamp ----------------
  function automatic logic [FIELD_W-1:0] finish(input logic signed [SW-1:0] s);
    logic signed [SW-1:0] v;
    v = (s + HALF2) >>> RS2;
    if (v > LIM)  v = LIM;
    if (v < -LIM) v = -LIM;
    if (v > FMAX) v = FMAX;
    if (v < FMIN) v = FMIN;
    return v[FIELD_W-1:0];
  endfunction

  logic signed [SW-1:0] sum [0:NUM_ENTRIES-1];
  assign sum[0] = SW'(pr_r[0]);
  assign sum[1] = SW'(pr_r[1]) - SW'(pr_r[2]);
  assign sum[2] = SW'(pr_r[3]) + SW'(pr_r[4]);
  assign sum[3] = SW'(pr_r[5]);
  assign sum[4] = SW'(pr_r[6]) + SW'(pr_r[7]);
  assign sum[5] = SW'(pr_r[8]) - SW'(pr_r[9]);
  assign sum[6] = SW'(pr_r[10]);
  assign sum[7] = SW'(pr_r[11]);
  assign sum[8] = SW'(pr_r[12]);

  logic out_vld_r;
  assign out_tvalid = out_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance) begin
      out_vld_r <= mv_r;
    end
  end

  for (genvar e = 0; e < NUM_ENTRIES; e++) begin : g_out
    always_ff @(posedge clk) begin
      if (advance) begin
        out_tdata[e*FIELD_W +: FIELD_W] <= finish(sum[e]);
      end
    end
  end

`ifndef SYNTH
  a_rst_clears: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("output valid set after reset");
  a_m00_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[15:0]) <= $signed(32'(LIM))) &&
                   ($signed(out_tdata[15:0]) >= -$signed(32'(LIM))))
    else $error("m00 out of range");
  a_m22_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> ($signed(out_tdata[143:128]) <= $signed(32'(LIM))) &&
                   ($signed(out_tdata[143:128]) >= -$signed(32'(LIM))))
    else $error("m22 out of range");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (mv_r && out_tvalid && !out_tready) |=> mv_r && out_tvalid)
    else $error("pipeline word lost during stall");
`endif

endmodule

`default_nettype wire

/* verif/euler_angles_to_rotation_checker.sv */
// ----------------------------------------------------------------------------
// euler_angles_to_rotation_checker
// Watches both stream channels of the rotation core, computes the expected
// rotation matrix entries for every accepted angle word and compares them
// field by field with every accepted output word, oldest first.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module euler_angles_to_rotation_checker (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  input  wire logic         in_tready,
  input  wire logic [47:0]  in_tdata,
  input  wire logic         out_tvalid,
  input  wire logic         out_tready,
  input  wire logic [143:0] out_tdata,
  output int                mismatches,
  output int                pending
);

  localparam int ANGLE_W = 16;
  localparam int FRAC_W  = 14;
  localparam int TRIG_W  = FRAC_W + 4;
  localparam int NSTEP   = 24;
  localparam int CFRAC   = 30;
  localparam longint GAIN0 = 64'sd652032874;

  localparam longint ATAN_TBL [NSTEP] = '{
    64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
    64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
    64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
    64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
    64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051};

  logic [143:0] matrix_q [$];

  function automatic longint rnd_shift(longint v, int n);
    return (v + (64'sd1 <<< (n - 1))) >>> n;
  endfunction

  function automatic void angle_trig(input logic [15:0] ang, output longint sn,
                                     output longint cs);
    logic [31:0] phase;
    logic [31:0] dd;
    logic [1:0]  quad;
    longint x, y, z, xs, ys;
    phase = {ang, 16'h0};
    quad  = 2'((phase + 32'h2000_0000) >> 30);
    dd    = phase - {quad, 30'h0};
    z     = longint'(signed'(dd));
    x     = GAIN0;
    y     = 0;
    for (int i = 0; i < NSTEP; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x = x - ys; y = y + xs; z = z - ATAN_TBL[i];
      end else begin
        x = x + ys; y = y - xs; z = z + ATAN_TBL[i];
      end
    end
    case (quad)
      2'd0: begin cs = x;  sn = y;  end
      2'd1: begin cs = -y; sn = x;  end
      2'd2: begin cs = -x; sn = -y; end
      default: begin cs = y; sn = -x; end
    endcase
    cs = rnd_shift(cs, CFRAC - TRIG_W);
    sn = rnd_shift(sn, CFRAC - TRIG_W);
  endfunction

  function automatic logic [15:0] to_entry(longint wide);
    longint v;
    longint lim;
    v   = rnd_shift(wide, 2 * TRIG_W - FRAC_W);
    lim = 64'sd1 <<< FRAC_W;
    if (v > lim) v = lim;
    if (v < -lim) v = -lim;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return v[15:0];
  endfunction

  function automatic logic [143:0] rotation_of(logic [47:0] angles);
    longint sx, cx, sy, cy, sz, cz, pss, psc;
    logic [143:0] m;
    angle_trig(angles[15:0], sx, cx);
    angle_trig(angles[31:16], sy, cy);
    angle_trig(angles[47:32], sz, cz);
    pss = rnd_shift(sy * sx, TRIG_W);
    psc = rnd_shift(sy * cx, TRIG_W);
    m[15:0]    = to_entry(cz * cy);
    m[31:16]   = to_entry(cz * pss - sz * cx);
    m[47:32]   = to_entry(cz * psc + sz * sx);
    m[63:48]   = to_entry(sz * cy);
    m[79:64]   = to_entry(sz * pss + cz * cx);
    m[95:80]   = to_entry(sz * psc - cz * sx);
    m[111:96]  = to_entry(-sy * (64'sd1 <<< TRIG_W));
    m[127:112] = to_entry(cy * sx);
    m[143:128] = to_entry(cy * cx);
    return m;
  endfunction

  assign pending = matrix_q.size();

  initial mismatches = 0;

  always @(posedge clk) begin
    logic [143:0] want;
    if (rst_n && in_tvalid && in_tready) begin
      matrix_q = {matrix_q, rotation_of(in_tdata)};
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (matrix_q.size() == 0) begin
        $display("%0t: unexpected word, expected none, actual %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = matrix_q.pop_front();
        for (int e = 0; e < 9; e++) begin
          if (out_tdata[e*16 +: 16] !== want[e*16 +: 16]) begin
            $display("%0t: m%0d%0d expected %0d actual %0d", $time, e / 3, e % 3,
                     $signed(want[e*16 +: 16]), $signed(out_tdata[e*16 +: 16]));
            mismatches++;
          end
        end
      end
    end
  end

endmodule

/* verif/tb_euler_angles_to_rotation_core.sv */
// ----------------------------------------------------------------------------
// tb_euler_angles_to_rotation_core
// Drives directed and random angle words into the rotation core with random
// gaps on both sides and one long output hold-off; the checker compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_euler_angles_to_rotation_core;

  localparam int RANDOM_WORDS = 700;
  localparam int CYCLE_LIMIT  = 200000;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [47:0]  in_tdata = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [143:0] out_tdata;
  int           mismatches;
  int           pending;
  int           cycles = 0;
  bit           hold_off = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  euler_angles_to_rotation_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata)
  );

  euler_angles_to_rotation_checker chk (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .mismatches(mismatches), .pending(pending)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  // Random receiver stalls; a long hold-off once early in the random part.
  initial begin
    int gap;
    int stretch;
    @(posedge clk);
    forever begin
      if (hold_off) begin
        out_tready <= 1'b0;
        stretch = 0;
        while (stretch < 300) begin
          @(posedge clk);
          stretch++;
        end
        hold_off = 1'b0;
      end
      gap = (cycles % 3000 < 600) ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      @(posedge clk);
      while (!out_tvalid) @(posedge clk);
    end
  end

  task automatic send_angles(input logic [15:0] ax, input logic [15:0] ay,
                             input logic [15:0] az, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {az, ay, ax};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(0, 3))
      0: return 16'($urandom_range(0, 3) << 14) + 16'($urandom_range(0, 8)) - 16'd4;
      1: return 16'($urandom_range(0, 7) << 13) + 16'($urandom_range(0, 2)) - 16'd1;
      default: return 16'($urandom);
    endcase
  endfunction

  initial begin
    logic [15:0] edges [12];
    int settle;
    edges = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF, 16'h4000, 16'hC000,
              16'h2000, 16'h1FFF, 16'hE000, 16'h0001, 16'h6000, 16'hA000};
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // extremes, quadrant boundaries and octant folds
    for (int i = 0; i < 12; i++) begin
      send_angles(edges[i], edges[(i + 4) % 12], edges[(i + 7) % 12], 1'b0);
    end
    send_angles(16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0);
    send_angles(16'h8000, 16'h8000, 16'h8000, 1'b0);
    send_angles(16'h0000, 16'h4000, 16'h0000, 1'b0);
    send_angles(16'h5555, 16'hAAAA, 16'h3333, 1'b0);
    send_angles(16'hAAAA, 16'h5555, 16'hCCCC, 1'b0);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == 50) hold_off = 1'b1;
      send_angles(pick_angle(), pick_angle(), pick_angle(), (n % 200) < 40);
    end
    in_tvalid <= 1'b0;

    while (pending != 0) @(posedge clk);
    settle = 0;
    while (settle < 40) begin
      @(posedge clk);
      settle++;
    end
    if (mismatches == 0 && pending == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
